/* src/rtcf_pkg.sv */
// Package with shared constants, types and the leg record for the tour cost checker.
`default_nettype none
package rtcf_pkg;
  localparam int COORD_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int CFG_W             = 32;
  localparam int CFG_IDX_W         = 2;
  localparam int TIME_W            = 48;
  localparam int LOAD_W            = 40;
  localparam int COST_W            = 34;
  localparam int FIELD_W           = 16;
  localparam int IN_TDATA_W        = 80;
  localparam int OUT_TDATA_W       = 40;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_A      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_B      = 2'd2;

  // Kinds of work the front hands to the back.
  typedef enum logic [1:0] {
    JOB_FIRST = 2'd0,
    JOB_LEG   = 2'd1,
    JOB_WRAP  = 2'd2
  } job_kind_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_ROOT = 2'd1,
    BK_ACC  = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

  // One queued job: a leg (or the first stop) with its stop data.
  typedef struct packed {
    job_kind_t          kind;
    logic [FIELD_W-1:0] dx;
    logic [FIELD_W-1:0] dy;
    logic [FIELD_W-1:0] prev_svc;
    logic [FIELD_W-1:0] demand_a;
    logic [FIELD_W-1:0] demand_b;
    logic               is_depot;
    logic               last_stop;
  } job_t;
endpackage
`default_nettype wire

/* src/rtcf_front.sv */
// Front end: accepts stop words, tracks previous and first stop, emits leg jobs.
`default_nettype none
module rtcf_front
  import rtcf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [FIELD_W-1:0] x_in,
  input  wire logic [FIELD_W-1:0] y_in,
  input  wire logic [FIELD_W-1:0] svc_in,
  input  wire logic [FIELD_W-1:0] da_in,
  input  wire logic [FIELD_W-1:0] db_in,
  input  wire logic          depot_in,
  input  wire logic          last_in,
  output logic               job_valid,
  input  wire logic          job_ready,
  output job_t               job
);
  localparam logic [FIELD_W-1:0] CMASK = FIELD_W'((64'd1 << COORD_BITS) - 64'd1);

  logic               have_previous;
  logic               wrap_pending;
  logic [FIELD_W-1:0] previous_x, previous_y, previous_service, first_x, first_y;
  logic [FIELD_W-1:0] xm, ym, tx, ty;

  assign xm = x_in & CMASK;
  assign ym = y_in & CMASK;
  assign tx = wrap_pending ? first_x : xm;
  assign ty = wrap_pending ? first_y : ym;

  // Stop words are taken only when no wrap leg is still to be issued.
  assign in_ready  = !wrap_pending && job_ready;
  assign job_valid = wrap_pending || in_valid;

  // Build the job from the current stop or the pending wrap leg.
  always_comb begin
    job.dx        = (previous_x > tx) ? previous_x - tx : tx - previous_x;
    job.dy        = (previous_y > ty) ? previous_y - ty : ty - previous_y;
    job.prev_svc  = previous_service;
    job.demand_a  = da_in;
    job.demand_b  = db_in;
    job.is_depot  = depot_in;
    job.last_stop = last_in;
    if (wrap_pending) begin
      job.kind      = JOB_WRAP;
      job.demand_a  = '0;
      job.demand_b  = '0;
      job.is_depot  = 1'b0;
      job.last_stop = 1'b1;
    end else if (have_previous) begin
      job.kind = JOB_LEG;
    end else begin
      job.kind = JOB_FIRST;
    end
  end

  // Previous and first stop registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous    <= 1'b0;
      wrap_pending     <= 1'b0;
      previous_x       <= '0;
      previous_y       <= '0;
      previous_service <= '0;
      first_x          <= '0;
      first_y          <= '0;
    end else if (wrap_pending) begin
      if (job_ready) begin
        wrap_pending     <= 1'b0;
        have_previous    <= 1'b0;
        previous_x       <= '0;
        previous_y       <= '0;
        previous_service <= '0;
        first_x          <= '0;
        first_y          <= '0;
      end
    end else if (in_valid && job_ready) begin
      if (!have_previous) begin
        first_x <= xm;
        first_y <= ym;
      end
      have_previous    <= 1'b1;
      previous_x       <= xm;
      previous_y       <= ym;
      previous_service <= svc_in;
      wrap_pending     <= last_in;
    end
  end
endmodule
`default_nettype wire

/* src/rtcf_queue.sv */
// Short two-entry queue of jobs between the front and back ends.
`default_nettype none
module rtcf_queue
  import rtcf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  job_t      wr_job,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_job
);
  job_t       slot [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slot[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr <= ~wptr;
      if (rd_valid && rd_ready) rptr <= ~rptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slot[wptr] <= wr_job;
  end
endmodule
`default_nettype wire

/* src/rtcf_back.sv */
// Back end: serial square root per leg, accumulation, checks and result word.
`default_nettype none
module rtcf_back
  import rtcf_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             job_valid,
  output logic                  job_ready,
  input  job_t                  job,
  input  wire logic [CFG_W-1:0] time_limit,
  input  wire logic [CFG_W-1:0] cap_a,
  input  wire logic [CFG_W-1:0] cap_b,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_feasible,
  output logic [COST_W-1:0]     out_cost
);
  localparam int RBITS = 17 + FRACTION_BITS;   // root width
  localparam int SQ_W  = 33;                    // dx^2+dy^2 width
  // The radicand is consumed two bits per root bit, so it spans twice the root width.
  localparam int RAD_W = 2*RBITS;
  localparam int REM_W = RBITS + 2;
  localparam int CNT_W = $clog2(RBITS + 1);
  localparam logic [TIME_W-1:0] TMAX = '1;
  localparam logic [LOAD_W-1:0] LMAX = '1;
  localparam logic [COST_W-1:0] CMAX = '1;

  bk_state_t state, state_next;
  job_t      cur;
  logic [SQ_W-1:0]  sq;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [RBITS-1:0] root;
  logic [CNT_W-1:0] steps;
  logic [TIME_W-1:0] route_time_acc;
  logic [LOAD_W-1:0] load_a_acc, load_b_acc;
  logic [COST_W-1:0] tour_cost_acc;
  logic              failed_flag;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              take;
  logic [TIME_W:0]   leg, time_sum, cost_sum;
  logic [TIME_W-1:0] time_new, time_lim;
  logic [COST_W-1:0] cost_new;
  logic [LOAD_W:0]   la_sum, lb_sum;
  logic [LOAD_W-1:0] la_new, lb_new, la_base, lb_base;
  logic              is_leg, time_fail, load_fail;

  // One root digit per cycle.
  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign take   = rem_sh >= trial;

  // Leg amount and saturating sums.
  assign is_leg   = (cur.kind != JOB_FIRST);
  assign leg      = (TIME_W+1)'(root) + ((TIME_W+1)'(cur.prev_svc) << FRACTION_BITS);
  assign time_sum = (TIME_W+1)'(route_time_acc) + leg;
  assign time_new = is_leg ? (time_sum[TIME_W] ? TMAX : time_sum[TIME_W-1:0])
                           : route_time_acc;
  assign cost_sum = (TIME_W+1)'(tour_cost_acc) + leg;
  assign cost_new = !is_leg ? tour_cost_acc
                  : ((cost_sum > (TIME_W+1)'(CMAX)) ? CMAX : cost_sum[COST_W-1:0]);
  assign time_lim = TIME_W'(time_limit) << FRACTION_BITS;
  assign time_fail = is_leg && (time_new > time_lim);
  assign la_base  = (is_leg && cur.is_depot) ? '0 : load_a_acc;
  assign lb_base  = (is_leg && cur.is_depot) ? '0 : load_b_acc;
  assign la_sum   = (LOAD_W+1)'(la_base) + (LOAD_W+1)'(cur.demand_a);
  assign lb_sum   = (LOAD_W+1)'(lb_base) + (LOAD_W+1)'(cur.demand_b);
  assign la_new   = la_sum[LOAD_W] ? LMAX : la_sum[LOAD_W-1:0];
  assign lb_new   = lb_sum[LOAD_W] ? LMAX : lb_sum[LOAD_W-1:0];
  assign load_fail = (cur.kind != JOB_WRAP) &&
                     ((la_new > LOAD_W'(cap_a)) || (lb_new > LOAD_W'(cap_b)));

  assign job_ready = (state == BK_IDLE);
  assign out_valid = (state == BK_OUT);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_valid) state_next = BK_ROOT;
      BK_ROOT: if (steps == CNT_W'(1)) state_next = BK_ACC;
      BK_ACC:  state_next = (cur.kind == JOB_WRAP) ? BK_OUT : BK_IDLE;
      BK_OUT:  if (out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // Square of the leg vector, taken as the job arrives.
  assign sq = SQ_W'({16'd0, job.dx} * {16'd0, job.dx}) +
              SQ_W'({16'd0, job.dy} * {16'd0, job.dy});

  // Datapath and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_time_acc <= '0;
      load_a_acc     <= '0;
      load_b_acc     <= '0;
      tour_cost_acc  <= '0;
      failed_flag    <= 1'b0;
    end else begin
      unique case (state)
        BK_IDLE: if (job_valid) begin
          cur   <= job;
          rad   <= RAD_W'({sq, {(2*FRACTION_BITS){1'b0}}});
          rem   <= '0;
          root  <= '0;
          steps <= CNT_W'(RBITS);
        end
        BK_ROOT: begin
          rad   <= rad << 2;
          rem   <= take ? rem_sh - trial : rem_sh;
          root  <= {root[RBITS-2:0], take};
          steps <= steps - CNT_W'(1);
        end
        BK_ACC: begin
          tour_cost_acc <= cost_new;
          if (cur.kind == JOB_WRAP) begin
            out_feasible <= !(failed_flag || time_fail);
            out_cost     <= cost_new;
          end else begin
            route_time_acc <= (is_leg && cur.is_depot) ? '0 : time_new;
            load_a_acc     <= la_new;
            load_b_acc     <= lb_new;
            failed_flag    <= failed_flag || time_fail || load_fail;
          end
        end
        BK_OUT: if (out_ready) begin
          route_time_acc <= '0;
          load_a_acc     <= '0;
          load_b_acc     <= '0;
          tour_cost_acc  <= '0;
          failed_flag    <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/route_tour_cost_and_feasibility.sv */
// Top level of the route tour cost and feasibility checker.
// Stops enter in tour order on s_axis; each stop after the first yields a leg whose
// distance is a fixed-point square root, rounded down, computed one result bit per cycle;
// every stop, the first included, makes one pass through the back end, and a
// last stop adds a second such pass for the wrap leg plus the result word.
// A two-entry queue lets the front take up to two stops ahead of the back end.
// Registers: 0 route time limit, 1 capacity a, 2 capacity b; write only when idle.
`default_nettype none
module route_tour_cost_and_feasibility
  import rtcf_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // stop_x, stop_y, service_time, demand_a, demand_b
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tlast,   // last_stop
  input  wire logic                   s_axis_tuser,   // is_depot
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // feasible, total_cost, zero fill
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);
  logic [CFG_W-1:0] route_time_limit, capacity_a, capacity_b;
  logic  fq_valid, fq_ready, qb_valid, qb_ready, feasible;
  job_t  fq_job, qb_job;
  logic [COST_W-1:0] total_cost;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_time_limit <= '1;
      capacity_a       <= '1;
      capacity_b       <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIME_LIMIT: route_time_limit <= cfg_wdata;
        REG_CAP_A:      capacity_a       <= cfg_wdata;
        REG_CAP_B:      capacity_b       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rtcf_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .x_in(s_axis_tdata[15:0]), .y_in(s_axis_tdata[31:16]),
    .svc_in(s_axis_tdata[47:32]), .da_in(s_axis_tdata[63:48]),
    .db_in(s_axis_tdata[79:64]), .depot_in(s_axis_tuser), .last_in(s_axis_tlast),
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  rtcf_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  rtcf_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .time_limit(route_time_limit), .cap_a(capacity_a), .cap_b(capacity_b),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_feasible(feasible), .out_cost(total_cost)
  );

  assign m_axis_tdata = {5'd0, total_cost, feasible};
endmodule
`default_nettype wire

/* src/rtcf_checker.sv */
// Port-level checker for the tour cost block, bound to the top level.
`default_nettype none
module rtcf_checker
  import rtcf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   s_axis_tlast,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);
  // A result word holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Fill bits of the result are zero.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:COST_W+1] == '0)
    else $error("result fill bits set");

  // After a last stop, the next cycle cannot take another stop.
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("stop taken during wrap leg");

  // No result right after reset.
  a_rst: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result after reset");
endmodule

bind route_tour_cost_and_feasibility rtcf_checker u_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

/* tb/sv/route_tour_cost_and_feasibility_test.sv */
// Self-checking testbench for the route tour cost and feasibility checker.
module route_tour_cost_and_feasibility_test;
  import rtcf_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_STOPS = 1400;

  // Expected tour verdict held until the block emits it.
  typedef struct {
    logic              feasible;
    logic [COST_W-1:0] cost;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  route_tour_cost_and_feasibility dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Idling controls for the sender and the receiver.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned stops_sent = 0;
  longint unsigned cycles = 0;
  verdict_t verdicts[$];

  // Tour evaluator state and its copy of the limits.
  logic [31:0] time_limit, cap_a, cap_b;
  logic        started;
  logic [15:0] prev_x, prev_y, prev_svc, first_x, first_y;
  logic [47:0] route_time;
  logic [39:0] load_a, load_b;
  logic [33:0] tour_cost;
  logic        broken;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, rem, b;
    r = 0;
    rem = v;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned top);
    longint unsigned s;
    s = a + b;
    return (s > top) ? top : s;
  endfunction

  // Close the leg from the previous stop to (tx, ty).
  task automatic close_leg(logic [15:0] tx, logic [15:0] ty);
    longint unsigned dx, dy, leg;
    dx = (prev_x > tx) ? prev_x - tx : tx - prev_x;
    dy = (prev_y > ty) ? prev_y - ty : ty - prev_y;
    leg = floor_root((dx * dx + dy * dy) << 16) + (longint'(prev_svc) << 8);
    tour_cost = 34'(sat_sum(tour_cost, leg, (64'd1 << 34) - 1));
    route_time = 48'(sat_sum(route_time, leg, (64'd1 << 48) - 1));
    if (route_time > (longint'(time_limit) << 8)) broken = 1'b1;
  endtask

  task automatic clear_tour();
    started = 0; prev_x = 0; prev_y = 0; prev_svc = 0; first_x = 0; first_y = 0;
    route_time = 0; load_a = 0; load_b = 0; tour_cost = 0; broken = 0;
  endtask

  task automatic evaluate_stop(logic [15:0] x, y, svc, da, db, logic depot, logic last);
    verdict_t v;
    if (started) begin
      close_leg(x, y);
      if (depot) begin
        route_time = 0; load_a = 0; load_b = 0;
      end
    end else begin
      first_x = x; first_y = y; started = 1;
    end
    load_a = 40'(sat_sum(load_a, da, (64'd1 << 40) - 1));
    load_b = 40'(sat_sum(load_b, db, (64'd1 << 40) - 1));
    if (load_a > cap_a || load_b > cap_b) broken = 1'b1;
    prev_x = x; prev_y = y; prev_svc = svc;
    if (last) begin
      close_leg(first_x, first_y);
      v.feasible = ~broken;
      v.cost = tour_cost;
      verdicts.push_back(v);
      clear_tour();
    end
  endtask

  // Offer one stop word, with random gaps, and evaluate it once accepted.
  task automatic send_stop(logic [15:0] x, y, svc, da, db, logic depot, logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {db, da, svc, y, x};
    s_axis_tuser <= depot;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    evaluate_stop(x, y, svc, da, db, depot, last);
    stops_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    stop_sending();
    while (verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_TIME_LIMIT: time_limit = value;
      REG_CAP_A:      cap_a = value;
      REG_CAP_B:      cap_b = value;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [31:0] t, logic [31:0] a, logic [31:0] b);
    write_reg(REG_TIME_LIMIT, t);
    write_reg(REG_CAP_A, a);
    write_reg(REG_CAP_B, b);
  endtask

  // One random tour; coordinates are all wide or all clustered, other fields mix wide and small values.
  task automatic random_tour(int unsigned len);
    logic [15:0] x, y, svc, da, db;
    logic wide;
    wide = 1'($urandom_range(1));
    for (int unsigned i = 0; i < len; i++) begin
      x = 16'(wide ? $urandom : $urandom_range(300));
      y = 16'(wide ? $urandom : $urandom_range(300));
      svc = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(50));
      da = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(2000));
      db = 16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(2000));
      send_stop(x, y, svc, da, db, (i == 0) ? $urandom_range(3) != 0
                : $urandom_range(6) == 0, i == len - 1);
    end
  endtask

  task automatic test_directed();
    // Single-stop tours: the wrap leg is zero and only service time counts.
    send_stop(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_stop(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    // Opposite corners, both directions, exact and inexact roots.
    send_stop(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_stop(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_stop(16'd3, 16'd4, 16'd0, 16'd0, 16'hFFFF, 1'b0, 1'b1);
    send_stop(16'hFFFF, 16'h0000, 16'd10, 16'd1, 16'd1, 1'b1, 1'b0);
    send_stop(16'h0000, 16'hFFFF, 16'd10, 16'd1, 16'd1, 1'b0, 1'b0);
    send_stop(16'd1, 16'd1, 16'd0, 16'd2, 16'd2, 1'b1, 1'b0);
    send_stop(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b1);
    wait_idle();
    // Tight limits: over time, over each capacity, depot resets the route.
    set_limits(32'd100, 32'd50, 32'd60);
    send_stop(16'd0, 16'd0, 16'd0, 16'd50, 16'd0, 1'b1, 1'b0);
    send_stop(16'd60, 16'd0, 16'd0, 16'd0, 16'd60, 1'b0, 1'b0);
    send_stop(16'd0, 16'd0, 16'd0, 16'd50, 16'd60, 1'b1, 1'b1);
    send_stop(16'd0, 16'd0, 16'd0, 16'd51, 16'd0, 1'b1, 1'b1);
    send_stop(16'd0, 16'd0, 16'd0, 16'd0, 16'd61, 1'b1, 1'b1);
    send_stop(16'd0, 16'd0, 16'd101, 16'd0, 16'd0, 1'b1, 1'b1);
    send_stop(16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 1'b1, 1'b1);
    wait_idle();
    // Zero limits fail on any distance or demand at all.
    set_limits(32'd0, 32'd0, 32'd0);
    send_stop(16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
    send_stop(16'd5, 16'd5, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    send_stop(16'd6, 16'd5, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1);
    send_stop(16'd5, 16'd5, 16'd0, 16'd1, 16'd0, 1'b0, 1'b1);
    wait_idle();
  endtask

  // A long tour of maximal legs drives the cost into saturation.
  task automatic test_cost_saturation();
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 440; i++)
      send_stop(i[0] ? 16'hFFFF : 16'h0000, i[0] ? 16'hFFFF : 16'h0000, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 1'b0, i == 439);
    wait_idle();
  endtask

  task automatic test_random_tours(int unsigned target);
    int unsigned goal;
    goal = stops_sent + target;
    while (stops_sent < goal) random_tour($urandom_range(12, 1));
    wait_idle();
  endtask

  // The receiver holds off while the sender keeps offering stops.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 500;
    for (int i = 0; i < 12; i++) random_tour($urandom_range(3, 1));
    wait_idle();
  endtask

  // Receiver: random stalls, or a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result word with the oldest expected verdict.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h", m_axis_tdata);
      end else begin
        if (m_axis_tdata[0] !== verdicts[0].feasible ||
            m_axis_tdata[34:1] !== verdicts[0].cost) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected feasible %b cost %h, got feasible %b cost %h",
                     verdicts[0].feasible, verdicts[0].cost,
                     m_axis_tdata[0], m_axis_tdata[34:1]);
        end
        void'(verdicts.pop_front());
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("route_tour_cost_and_feasibility regression: fail");
      $finish;
    end
  end

  initial begin
    time_limit = '1;
    cap_a = '1;
    cap_b = '1;
    clear_tour();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_cost_saturation();
    // Phases of idling, each with its own limits.
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    idle_pct = 0;  stall_pct = 0;
    test_random_tours(RANDOM_STOPS / 4);
    set_limits(32'd150000, 32'd6000, 32'd6000);
    idle_pct = 58; stall_pct = 0;
    test_random_tours(RANDOM_STOPS / 4);
    set_limits(32'd400, 32'd1500, 32'd70000);
    idle_pct = 0;  stall_pct = 58;
    test_random_tours(RANDOM_STOPS / 4);
    set_limits($urandom, $urandom, $urandom_range(200000));
    idle_pct = 17; stall_pct = 17;
    test_random_tours(RANDOM_STOPS / 4);
    test_backpressure();
    if (mismatches == 0 && verdicts.size() == 0) begin
      $display("route_tour_cost_and_feasibility regression: pass");
    end else begin
      $display("route_tour_cost_and_feasibility regression: fail");
    end
    $finish;
  end
endmodule
